### hw/rtl/gds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_pkg: shared constants and calendar functions
// Month codes, block defaults, divide-by-100 reciprocal and leap/month rules.
// ----------------------------------------------------------------------------
package gds_pkg;

  localparam int unsigned MAX_YEAR_DEF  = 9999;
  localparam int unsigned MAX_STEPS_DEF = 65535;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_IO_W = 14;
  localparam int unsigned COUNT_W = 16;

  // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT, exact for y below 2**16
  localparam int unsigned DIV100_MUL   = 83887;
  localparam int unsigned DIV100_MUL_W = 17;
  localparam int unsigned DIV100_SHIFT = 23;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0] DAY_LAST  = 5'd31;

  localparam logic [6:0] CENT_LAST = 7'd99;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [6:0]         mod100;
    logic [1:0]         cent;
  } gds_cal_t;

  function automatic logic gds_is_leap(logic [6:0] mod100, logic [1:0] cent,
                                       logic [1:0] ylo);
    if (mod100 == 7'd0) begin
      return cent == 2'd0;
    end
    return ylo == 2'd0;
  endfunction

  function automatic logic [DAY_W-1:0] gds_month_len(logic [MONTH_W-1:0] month,
                                                     logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### hw/rtl/gds_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_if: request and response channels
// Valid/ready channels carrying the date step request and its result.
// ----------------------------------------------------------------------------
interface gds_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [4:0]  start_day;
  logic [3:0]  start_month;
  logic [13:0] start_year;
  logic [15:0] day_count;

  modport source (output valid, action, start_day, start_month, start_year, day_count,
                  input ready);
  modport sink   (input valid, action, start_day, start_month, start_year, day_count,
                  output ready);
endinterface

interface gds_rsp_if;
  logic        valid;
  logic        ready;
  logic [4:0]  result_day;
  logic [3:0]  result_month;
  logic [13:0] result_year;
  logic        date_valid;
  logic        out_of_range;

  modport source (output valid, result_day, result_month, result_year, date_valid,
                  out_of_range, input ready);
  modport sink   (input valid, result_day, result_month, result_year, date_valid,
                  out_of_range, output ready);
endinterface

### hw/rtl/gregorian_date_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_step: add or subtract days from a Gregorian date
// Sequencer around a shared one-day step unit and a year splitter.
// ----------------------------------------------------------------------------
// Sequence: ST_SPLIT1, ST_SPLIT2, ST_CHECK, then ST_RUN for N steps (N = day count,
//   clipped to MAX_STEPS, fewer if a limit is hit), then ST_FINISH; an invalid date
//   skips ST_RUN. A new request is taken only in ST_IDLE, after the last result is
//   loaded; the step unit moves the date one day per cycle; a held result stalls.
// Reset: clears the sequencer and the result valid flag; no stored tables.
module gregorian_date_step
  import gds_pkg::*;
#(
  parameter int unsigned MAX_YEAR  = MAX_YEAR_DEF,
  parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  gds_req_if.sink        req_i,
  gds_rsp_if.source      rsp_o
);

  localparam int unsigned YEAR_NEED = $clog2(MAX_YEAR + 1);
  localparam int unsigned YEAR_W    = (YEAR_NEED > YEAR_IO_W) ? YEAR_NEED : YEAR_IO_W;
  localparam logic [YEAR_W-1:0] YearMax = YEAR_W'(MAX_YEAR);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT1,
    ST_SPLIT2,
    ST_CHECK,
    ST_RUN,
    ST_FINISH
  } state_e;

  state_e             state_q;
  gds_cal_t           cal_q;
  logic [YEAR_W-1:0]  year_q;
  logic [COUNT_W-1:0] cnt_q;
  logic               back_q;
  logic               valid_q;
  logic               oor_q;

  logic               out_valid_q;
  logic [4:0]         out_day_q;
  logic [3:0]         out_month_q;
  logic [13:0]        out_year_q;
  logic               out_date_valid_q;
  logic               out_oor_q;

  logic [6:0]         split_mod100;
  logic [1:0]         split_cent;
  gds_cal_t           step_cal;
  logic [YEAR_W-1:0]  step_year;
  logic               step_limit;

  logic               req_take;
  logic               start_leap;
  logic               start_ok;
  logic [COUNT_W-1:0] cnt_clip;
  logic               out_free;
  logic               out_load;

  gds_year_split #(
    .YEAR_W (YEAR_W)
  ) u_split (
    .clk_i    (clk_i),
    .year_i   (year_q),
    .mod100_o (split_mod100),
    .cent_o   (split_cent)
  );

  gds_day_step #(
    .YEAR_W   (YEAR_W),
    .MAX_YEAR (MAX_YEAR)
  ) u_step (
    .back_i  (back_q),
    .cal_i   (cal_q),
    .year_i  (year_q),
    .cal_o   (step_cal),
    .year_o  (step_year),
    .limit_o (step_limit)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_take    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign out_load    = (state_q == ST_FINISH) && out_free;

  assign cnt_clip = (24'(req_i.day_count) > 24'(MAX_STEPS)) ? COUNT_W'(MAX_STEPS)
                                                           : req_i.day_count;

  assign start_leap = gds_is_leap(split_mod100, split_cent, year_q[1:0]);
  assign start_ok   = (cal_q.month >= MON_JAN) && (cal_q.month <= MON_DEC) &&
                      (cal_q.day >= DAY_FIRST) && (year_q <= YearMax) &&
                      (cal_q.day <= gds_month_len(cal_q.month, start_leap));

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_day   = out_day_q;
  assign rsp_o.result_month = out_month_q;
  assign rsp_o.result_year  = out_year_q;
  assign rsp_o.date_valid   = out_date_valid_q;
  assign rsp_o.out_of_range = out_oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      cal_q            <= '0;
      year_q           <= '0;
      cnt_q            <= '0;
      back_q           <= 1'b0;
      valid_q          <= 1'b0;
      oor_q            <= 1'b0;
      out_valid_q      <= 1'b0;
      out_day_q        <= '0;
      out_month_q      <= '0;
      out_year_q       <= '0;
      out_date_valid_q <= 1'b0;
      out_oor_q        <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_take) begin
            cal_q.day   <= req_i.start_day;
            cal_q.month <= req_i.start_month;
            year_q      <= YEAR_W'(req_i.start_year);
            cnt_q       <= cnt_clip;
            back_q      <= req_i.action;
            oor_q       <= 1'b0;
            state_q     <= ST_SPLIT1;
          end
        end
        ST_SPLIT1: state_q <= ST_SPLIT2;
        ST_SPLIT2: state_q <= ST_CHECK;
        ST_CHECK: begin
          cal_q.mod100 <= split_mod100;
          cal_q.cent   <= split_cent;
          valid_q      <= start_ok;
          state_q      <= start_ok ? ST_RUN : ST_FINISH;
        end
        ST_RUN: begin
          if (cnt_q == '0) begin
            state_q <= ST_FINISH;
          end else if (step_limit) begin
            oor_q   <= 1'b1;
            state_q <= ST_FINISH;
          end else begin
            cal_q  <= step_cal;
            year_q <= step_year;
            cnt_q  <= cnt_q - COUNT_W'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_day_q        <= cal_q.day;
            out_month_q      <= cal_q.month;
            out_year_q       <= year_q[YEAR_IO_W-1:0];
            out_date_valid_q <= valid_q;
            out_oor_q        <= oor_q;
            state_q          <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/gds_year_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_year_split: year modulo 100 and century modulo 4
// Two registered stages: reciprocal multiply, then remainder recovery.
// ----------------------------------------------------------------------------
module gds_year_split
  import gds_pkg::*;
#(
  parameter int unsigned YEAR_W = 14
) (
  input  logic              clk_i,
  input  logic [YEAR_W-1:0] year_i,
  output logic [6:0]        mod100_o,
  output logic [1:0]        cent_o
);

  localparam int unsigned PROD_W = YEAR_W + DIV100_MUL_W;
  localparam int unsigned QUOT_W = PROD_W - DIV100_SHIFT;

  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot_q;
  logic [YEAR_W-1:0] year_q;
  logic [YEAR_W-1:0] rem;

  assign prod = PROD_W'(year_i) * PROD_W'(DIV100_MUL);
  assign rem  = year_q - YEAR_W'(quot_q) * YEAR_W'(100);

  always_ff @(posedge clk_i) begin
    quot_q   <= prod[PROD_W-1:DIV100_SHIFT];
    year_q   <= year_i;
    mod100_o <= rem[6:0];
    cent_o   <= quot_q[1:0];
  end

endmodule

### hw/rtl/gds_day_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_day_step: one-day calendar step
// Moves a date one day forward or backward and flags the range limits.
// ----------------------------------------------------------------------------
module gds_day_step
  import gds_pkg::*;
#(
  parameter int unsigned YEAR_W   = 14,
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic              back_i,
  input  gds_cal_t          cal_i,
  input  logic [YEAR_W-1:0] year_i,
  output gds_cal_t          cal_o,
  output logic [YEAR_W-1:0] year_o,
  output logic              limit_o
);

  localparam logic [YEAR_W-1:0] YearMax = YEAR_W'(MAX_YEAR);

  logic             leap;
  logic [DAY_W-1:0] len_cur;
  logic [DAY_W-1:0] len_prev;

  assign leap     = gds_is_leap(cal_i.mod100, cal_i.cent, year_i[1:0]);
  assign len_cur  = gds_month_len(cal_i.month, leap);
  assign len_prev = gds_month_len(cal_i.month - MONTH_W'(1), leap);

  always_comb begin
    cal_o   = cal_i;
    year_o  = year_i;
    limit_o = 1'b0;
    if (!back_i) begin
      if (cal_i.day >= len_cur) begin
        if (cal_i.month == MON_DEC) begin
          if (year_i >= YearMax) begin
            limit_o = 1'b1;
          end else begin
            cal_o.day   = DAY_FIRST;
            cal_o.month = MON_JAN;
            year_o      = year_i + YEAR_W'(1);
            if (cal_i.mod100 == CENT_LAST) begin
              cal_o.mod100 = 7'd0;
              cal_o.cent   = cal_i.cent + 2'd1;
            end else begin
              cal_o.mod100 = cal_i.mod100 + 7'd1;
            end
          end
        end else begin
          cal_o.day   = DAY_FIRST;
          cal_o.month = cal_i.month + MONTH_W'(1);
        end
      end else begin
        cal_o.day = cal_i.day + DAY_W'(1);
      end
    end else begin
      if (cal_i.day <= DAY_FIRST) begin
        if (cal_i.month == MON_JAN) begin
          if (year_i == '0) begin
            limit_o = 1'b1;
          end else begin
            cal_o.day   = DAY_LAST;
            cal_o.month = MON_DEC;
            year_o      = year_i - YEAR_W'(1);
            if (cal_i.mod100 == 7'd0) begin
              cal_o.mod100 = CENT_LAST;
              cal_o.cent   = cal_i.cent - 2'd1;
            end else begin
              cal_o.mod100 = cal_i.mod100 - 7'd1;
            end
          end
        end else begin
          cal_o.month = cal_i.month - MONTH_W'(1);
          cal_o.day   = len_prev;
        end
      end else begin
        cal_o.day = cal_i.day - DAY_W'(1);
      end
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for gregorian_date_step
// Walks a directed table of date step requests, then a random stream of mostly
// real dates with random content, and idles both channels at random. Each
// result is checked per field against a typed or day-by-day predicted value.
// ----------------------------------------------------------------------------
module tb;
  import gds_pkg::*;

  localparam int unsigned MAX_YEAR     = MAX_YEAR_DEF;
  localparam int unsigned MAX_STEPS    = MAX_STEPS_DEF;
  localparam int unsigned N_DIRECTED   = 27;
  localparam int unsigned N_RANDOM     = 75;
  localparam int unsigned HOLD_AT      = 30;
  localparam int unsigned HOLD_CYCLES  = 1000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef enum logic {STEP_FWD = 1'b0, STEP_BACK = 1'b1} step_dir_e;

  typedef struct packed {
    step_dir_e            action;
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_IO_W-1:0] year;
    logic [COUNT_W-1:0]   count;
  } date_req_t;

  typedef struct packed {
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_IO_W-1:0] year;
    logic                 date_valid;
    logic                 out_of_range;
  } date_rsp_t;

  typedef struct packed {
    date_req_t req;
    logic      typed;
    date_rsp_t rsp;
  } date_row_t;

  localparam date_rsp_t NO_RSP = '0;

  localparam date_row_t DIRECTED [N_DIRECTED] = '{
    '{'{STEP_FWD,  5'd1,  4'd1,  14'd2000,  16'd0},     1'b1, '{5'd1,  4'd1,  14'd2000,  1'b1, 1'b0}},
    '{'{STEP_FWD,  5'd0,  4'd0,  14'd0,     16'd0},     1'b1, '{5'd0,  4'd0,  14'd0,     1'b0, 1'b0}},
    '{'{STEP_BACK, 5'd31, 4'd15, 14'd16383, 16'd65535}, 1'b1, '{5'd31, 4'd15, 14'd16383, 1'b0, 1'b0}},
    '{'{STEP_FWD,  5'd31, 4'd12, 14'd9999,  16'd1},     1'b1, '{5'd31, 4'd12, 14'd9999,  1'b1, 1'b1}},
    '{'{STEP_BACK, 5'd1,  4'd1,  14'd0,     16'd1},     1'b1, '{5'd1,  4'd1,  14'd0,     1'b1, 1'b1}},
    '{'{STEP_FWD,  5'd0,  4'd1,  14'd2000,  16'd5},     1'b1, '{5'd0,  4'd1,  14'd2000,  1'b0, 1'b0}},
    '{'{STEP_FWD,  5'd15, 4'd0,  14'd2000,  16'd3},     1'b1, '{5'd15, 4'd0,  14'd2000,  1'b0, 1'b0}},
    '{'{STEP_BACK, 5'd10, 4'd13, 14'd100,   16'd1},     1'b1, '{5'd10, 4'd13, 14'd100,   1'b0, 1'b0}},
    '{'{STEP_FWD,  5'd31, 4'd4,  14'd2021,  16'd2},     1'b1, '{5'd31, 4'd4,  14'd2021,  1'b0, 1'b0}},
    '{'{STEP_FWD,  5'd29, 4'd2,  14'd1900,  16'd1},     1'b1, '{5'd29, 4'd2,  14'd1900,  1'b0, 1'b0}},
    '{'{STEP_BACK, 5'd1,  4'd1,  14'd10000, 16'd1},     1'b1, '{5'd1,  4'd1,  14'd10000, 1'b0, 1'b0}},
    '{'{STEP_FWD,  5'd1,  4'd1,  14'd9999,  16'd65535}, 1'b1, '{5'd31, 4'd12, 14'd9999,  1'b1, 1'b1}},
    '{'{STEP_BACK, 5'd31, 4'd12, 14'd0,     16'd65535}, 1'b1, '{5'd1,  4'd1,  14'd0,     1'b1, 1'b1}},
    '{'{STEP_FWD,  5'd30, 4'd12, 14'd9999,  16'd2},     1'b1, '{5'd31, 4'd12, 14'd9999,  1'b1, 1'b1}},
    '{'{STEP_FWD,  5'd29, 4'd2,  14'd2000,  16'd1},     1'b0, NO_RSP},
    '{'{STEP_FWD,  5'd28, 4'd2,  14'd1900,  16'd1},     1'b0, NO_RSP},
    '{'{STEP_FWD,  5'd28, 4'd2,  14'd2004,  16'd1},     1'b0, NO_RSP},
    '{'{STEP_BACK, 5'd1,  4'd3,  14'd2100,  16'd1},     1'b0, NO_RSP},
    '{'{STEP_BACK, 5'd1,  4'd3,  14'd2400,  16'd1},     1'b0, NO_RSP},
    '{'{STEP_FWD,  5'd29, 4'd2,  14'd0,     16'd1},     1'b0, NO_RSP},
    '{'{STEP_FWD,  5'd31, 4'd12, 14'd1999,  16'd1},     1'b0, NO_RSP},
    '{'{STEP_BACK, 5'd1,  4'd1,  14'd2000,  16'd1},     1'b0, NO_RSP},
    '{'{STEP_BACK, 5'd2,  4'd1,  14'd0,     16'd1},     1'b0, NO_RSP},
    '{'{STEP_FWD,  5'd31, 4'd1,  14'd2023,  16'd30},    1'b0, NO_RSP},
    '{'{STEP_FWD,  5'd15, 4'd6,  14'd2024,  16'd65535}, 1'b0, NO_RSP},
    '{'{STEP_BACK, 5'd15, 4'd6,  14'd5000,  16'd65535}, 1'b0, NO_RSP},
    '{'{STEP_BACK, 5'd31, 4'd10, 14'd2023,  16'd100},   1'b0, NO_RSP}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  gds_req_if req_if ();
  gds_rsp_if rsp_if ();

  gregorian_date_step #(
    .MAX_YEAR (MAX_YEAR),
    .MAX_STEPS(MAX_STEPS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  date_rsp_t   pending_dates [$];
  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_errors    = 0;
  int unsigned n_invalid   = 0;
  int unsigned n_saturated = 0;

  function automatic bit is_leap(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    if (m == MON_FEB) begin
      return is_leap(y) ? 29 : 28;
    end
    if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic bit is_real_date(date_req_t r);
    return r.month >= MON_JAN && r.month <= MON_DEC && r.day >= DAY_FIRST &&
           r.year <= MAX_YEAR && r.day <= days_in_month(r.month, r.year);
  endfunction

  function automatic date_rsp_t step_date(date_req_t r);
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned n;
    bit          oor;
    date_rsp_t   res;
    d   = r.day;
    m   = r.month;
    y   = r.year;
    n   = r.count;
    oor = 1'b0;
    if (n > MAX_STEPS) n = MAX_STEPS;
    res.date_valid = is_real_date(r);
    if (res.date_valid) begin
      for (int unsigned i = 0; i < n && !oor; i++) begin
        if (r.action == STEP_FWD) begin
          if (d >= days_in_month(m, y)) begin
            if (m == MON_DEC) begin
              if (y >= MAX_YEAR) begin
                oor = 1'b1;
              end else begin
                d = 1;
                m = 1;
                y++;
              end
            end else begin
              d = 1;
              m++;
            end
          end else begin
            d++;
          end
        end else begin
          if (d <= 1) begin
            if (m == MON_JAN) begin
              if (y == 0) begin
                oor = 1'b1;
              end else begin
                d = 31;
                m = 12;
                y--;
              end
            end else begin
              m--;
              d = days_in_month(m, y);
            end
          end else begin
            d--;
          end
        end
      end
    end
    res.day          = DAY_W'(d);
    res.month        = MONTH_W'(m);
    res.year         = YEAR_IO_W'(y);
    res.out_of_range = oor;
    return res;
  endfunction

  // hold valid high across back-to-back requests; drop it only for a gap
  task automatic drive_request(date_req_t r, date_rsp_t exp_rsp, int unsigned gap);
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.action      <= r.action;
    req_if.start_day   <= r.day;
    req_if.start_month <= r.month;
    req_if.start_year  <= r.year;
    req_if.day_count   <= r.count;
    do @(posedge clk_i); while (!req_if.ready);
    pending_dates.push_back(exp_rsp);
    n_sent++;
  endtask

  initial begin : req_side
    date_req_t   r;
    date_rsp_t   e;
    int unsigned gap;
    int unsigned kind;
    int unsigned len;
    int unsigned y;
    req_if.valid       = 1'b0;
    req_if.action      = 1'b0;
    req_if.start_day   = '0;
    req_if.start_month = '0;
    req_if.start_year  = '0;
    req_if.day_count   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < N_DIRECTED; k++) begin
      r = DIRECTED[k].req;
      e = DIRECTED[k].typed ? DIRECTED[k].rsp : step_date(r);
      drive_request(r, e, $urandom_range(0, 6));
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      kind     = $urandom_range(0, 9);
      r.action = step_dir_e'($urandom_range(0, 1));
      if (kind < 2) begin
        // noise: any field value, short count if it lands on a real date
        r.day   = DAY_W'($urandom);
        r.month = MONTH_W'($urandom);
        r.year  = YEAR_IO_W'($urandom);
        r.count = COUNT_W'($urandom);
        if (is_real_date(r)) r.count = COUNT_W'($urandom_range(0, 300));
      end else begin
        case ($urandom_range(0, 4))
          0:       y = $urandom_range(0, 3);
          1:       y = $urandom_range(MAX_YEAR - 3, MAX_YEAR);
          2:       y = $urandom_range(0, 99) * 100;
          default: y = $urandom_range(0, MAX_YEAR);
        endcase
        r.year  = YEAR_IO_W'(y);
        r.month = MONTH_W'($urandom_range(1, 12));
        len     = days_in_month(r.month, r.year);
        case ($urandom_range(0, 3))
          0:       r.day = DAY_FIRST;
          1:       r.day = DAY_W'(len);
          default: r.day = DAY_W'($urandom_range(1, len));
        endcase
        if (i % 20 == 7) begin
          r.count = COUNT_W'($urandom);
        end else if (kind == 2) begin
          r.count = COUNT_W'($urandom_range(0, 3));
        end else begin
          r.count = COUNT_W'($urandom_range(0, 400));
        end
      end
      gap = (i >= 40 && i < 60) ? 0 : $urandom_range(0, 6);
      drive_request(r, step_date(r), gap);
    end
    @(negedge clk_i);
    req_if.valid <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests (%0d directed, %0d random), %0d results checked",
             n_sent, N_DIRECTED, N_RANDOM, n_checked);
    $display("of those %0d had invalid dates and %0d saturated at a year limit",
             n_invalid, n_saturated);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : rsp_side
    date_rsp_t   exp_rsp;
    date_rsp_t   got;
    int unsigned stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (n_checked == HOLD_AT) begin
        stall = HOLD_CYCLES;
      end else if (n_checked >= 60 && n_checked < 85) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 6);
      end
      @(negedge clk_i);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      got = '{rsp_if.result_day, rsp_if.result_month, rsp_if.result_year,
              rsp_if.date_valid, rsp_if.out_of_range};
      if (pending_dates.size() == 0) begin
        $error("result with no request outstanding");
        n_errors++;
      end else begin
        exp_rsp = pending_dates.pop_front();
        if (got.day !== exp_rsp.day) begin
          $error("result_day: expected %0d, actual %0d", exp_rsp.day, got.day);
          n_errors++;
        end
        if (got.month !== exp_rsp.month) begin
          $error("result_month: expected %0d, actual %0d", exp_rsp.month, got.month);
          n_errors++;
        end
        if (got.year !== exp_rsp.year) begin
          $error("result_year: expected %0d, actual %0d", exp_rsp.year, got.year);
          n_errors++;
        end
        if (got.date_valid !== exp_rsp.date_valid) begin
          $error("date_valid: expected %0d, actual %0d", exp_rsp.date_valid,
                 got.date_valid);
          n_errors++;
        end
        if (got.out_of_range !== exp_rsp.out_of_range) begin
          $error("out_of_range: expected %0d, actual %0d", exp_rsp.out_of_range,
                 got.out_of_range);
          n_errors++;
        end
        if (!exp_rsp.date_valid) n_invalid++;
        if (exp_rsp.out_of_range) n_saturated++;
        n_checked++;
      end
    end
  end

  initial begin : watchdog
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### gregorian_date_step.f
hw/rtl/gds_pkg.sv
hw/rtl/gds_if.sv
hw/rtl/gds_year_split.sv
hw/rtl/gds_day_step.sv
hw/rtl/gregorian_date_step.sv
tb/tb.sv
